>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication checked every clock edge outside reset.
`define CHECK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHECK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

>>> hw/rtl/ptq_pkg.sv
`timescale 1ns / 1ps
package ptq_pkg;
   localparam int NumJobs = 64;
   localparam int NumPrio = 4;
   localparam int QueueDepth = 64;
   localparam int MaxWait = 15;
   localparam int JobW = $clog2(NumJobs);
   localparam int PrioW = (NumPrio > 1) ? $clog2(NumPrio) : 1;
   localparam int QPtrW = $clog2(QueueDepth);
   localparam int QFillW = $clog2(QueueDepth + 1);
   localparam int WaitW = $clog2(MaxWait + 1);
   localparam int TotalW = 9;
   localparam int StoreDepth = NumPrio * QueueDepth;
   localparam int StoreAw = $clog2(StoreDepth);

   typedef enum logic [2:0] {
      OP_DEFINE = 3'd0, OP_LINK = 3'd1, OP_SUBMIT = 3'd2,
      OP_PICK = 3'd3, OP_COMPLETE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE = 3'd0, ST_NONE = 3'd1, ST_FULL = 3'd2,
      ST_HELD = 3'd3, ST_RELEASED = 3'd4
   } status_type;

   // One queued command between the front and the back.
   typedef struct packed {
      logic [2:0]      op;
      logic [5:0]      job;
      logic [1:0]      prio;
      logic [5:0]      succ;
   } cmd_type;
endpackage

>>> hw/rtl/ptq_ram.sv
`timescale 1ns / 1ps
module ptq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/ptq_front.sv
`timescale 1ns / 1ps
module ptq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2:0]       req_operation,
   input  logic [5:0]       req_job_id,
   input  logic [1:0]       req_job_priority_in,
   input  logic [5:0]       req_successor_id,
   input  logic             take,
   output logic             has_cmd,
   output ptq_pkg::cmd_type cmd,
   output logic             busy
);
   import ptq_pkg::*;
   // Two-entry queue; the front stops taking items while it is full.
   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    newc;

   always_comb begin
      newc.op = req_operation;
      newc.job = req_job_id;
      newc.prio = req_job_priority_in;
      newc.succ = req_successor_id;
      push = start && !busy;
      slot_in = slot_ff;
      cnt_in = cnt_ff;
      if (take) begin
         slot_in[0] = slot_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = newc;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff <= slot_in;
   end

   assign busy = cnt_ff[1];
   assign has_cmd = cnt_ff != 2'd0;
   assign cmd = slot_ff[0];
endmodule

>>> hw/rtl/ptq_back.sv
`timescale 1ns / 1ps
module ptq_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    has_cmd,
   input  ptq_pkg::cmd_type        cmd,
   output logic                    take,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [5:0]              rsp_job_out,
   output logic [8:0]              rsp_ready_count
);
   import ptq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_SUCC = 3'b010, S_EXEC = 3'b100
   } state_type;
   state_type state_ff, state_in;

   // Per-job flags. A clear attribute flag makes that job's priority and wait
   // count read as zero; a clear successor flag means the successor entry is
   // never looked at.
   logic [NumJobs-1:0] hass_ff, hass_in;
   logic [NumJobs-1:0] aval_ff, aval_in;

   logic [QPtrW-1:0]  head_ff [NumPrio];
   logic [QPtrW-1:0]  tail_ff [NumPrio];
   logic [QFillW-1:0] fill_ff [NumPrio];
   logic [TotalW-1:0] total_ff;
   cmd_type           cur_ff;

   logic [QPtrW-1:0]  head_in [NumPrio];
   logic [QPtrW-1:0]  tail_in [NumPrio];
   logic [QFillW-1:0] fill_in [NumPrio];
   logic [TotalW-1:0] total_in;

   logic              valid_ff, valid_in;
   logic [2:0]        status_ff, status_in;
   logic [5:0]        jout_ff, jout_in;

   // Queue store.
   logic               q_wr_en;
   logic [StoreAw-1:0] q_wr_addr, q_rd_addr;
   logic [JobW-1:0]    q_wr_data, q_rd_data;

   // Successor table.
   logic               s_wr_en;
   logic [JobW-1:0]    s_wr_addr, s_rd_addr;
   logic [JobW-1:0]    s_wr_data, s_rd_data;

   // Attribute table: priority above wait count.
   logic                    a_wr_en;
   logic [JobW-1:0]         a_wr_addr, a_rd_addr;
   logic [PrioW+WaitW-1:0]  a_wr_data, a_rd_data;
   logic [JobW-1:0]         a_addr_ff;

   // Pick target found in the dispatch cycle so the store read is ready next cycle.
   logic [PrioW-1:0] pick_q;
   logic             pick_any;
   logic [PrioW-1:0] pick_q_ff;
   logic             pick_any_ff;

   always_comb begin
      pick_q = '0;
      pick_any = 1'b0;
      for (int i = 0; i < NumPrio; i++) begin
         if (fill_ff[i] != '0) begin
            pick_q = PrioW'(i);
            pick_any = 1'b1;
         end
      end
      q_rd_addr = StoreAw'({pick_q, head_ff[pick_q]});
   end

   ptq_ram #(.Width(JobW), .Depth(StoreDepth)) u_store (
      .clock(clock), .wr_en(q_wr_en), .wr_addr(q_wr_addr), .wr_data(q_wr_data),
      .rd_addr(q_rd_addr), .rd_data(q_rd_data)
   );

   ptq_ram #(.Width(JobW), .Depth(NumJobs)) u_succ (
      .clock(clock), .wr_en(s_wr_en), .wr_addr(s_wr_addr), .wr_data(s_wr_data),
      .rd_addr(s_rd_addr), .rd_data(s_rd_data)
   );

   ptq_ram #(.Width(PrioW + WaitW), .Depth(NumJobs)) u_attr (
      .clock(clock), .wr_en(a_wr_en), .wr_addr(a_wr_addr), .wr_data(a_wr_data),
      .rd_addr(a_rd_addr), .rd_data(a_rd_data)
   );

   always_comb begin
      logic [JobW-1:0]  j, pj;
      logic [PrioW-1:0] pp, aprio;
      logic [WaitW-1:0] cur_wait;
      logic             do_push;
      state_in = state_ff;
      hass_in = hass_ff; aval_in = aval_ff;
      head_in = head_ff; tail_in = tail_ff; fill_in = fill_ff; total_in = total_ff;
      valid_in = 1'b0; status_in = status_ff; jout_in = jout_ff;
      take = 1'b0;
      q_wr_en = 1'b0; q_wr_addr = '0; q_wr_data = '0;
      s_wr_en = 1'b0; s_wr_addr = '0; s_wr_data = '0;
      a_wr_en = 1'b0; a_wr_addr = '0; a_wr_data = '0;
      j = cur_ff.job[JobW-1:0];
      s_rd_addr = j;
      a_rd_addr = j;
      // Attributes of the entry read in the previous cycle.
      if (aval_ff[a_addr_ff]) begin
         aprio = a_rd_data[PrioW+WaitW-1:WaitW];
         cur_wait = a_rd_data[WaitW-1:0];
      end else begin
         aprio = '0;
         cur_wait = '0;
      end
      pj = j;
      pp = aprio;
      do_push = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            s_rd_addr = cmd.job[JobW-1:0];
            if (cmd.op == OP_LINK) begin
               a_rd_addr = cmd.succ[JobW-1:0];
            end else begin
               a_rd_addr = cmd.job[JobW-1:0];
            end
            if (has_cmd) begin
               take = 1'b1;
               if (cmd.op == OP_COMPLETE) begin
                  state_in = S_SUCC;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SUCC: begin
            // The successor is known now; fetch its attributes.
            if (hass_ff[j]) begin
               a_rd_addr = s_rd_data;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            valid_in = 1'b1;
            status_in = ST_DONE;
            jout_in = '0;
            case (cur_ff.op)
               OP_DEFINE: begin
                  a_wr_en = 1'b1;
                  a_wr_addr = j;
                  a_wr_data = {cur_ff.prio[PrioW-1:0], WaitW'(0)};
                  aval_in[j] = 1'b1;
                  hass_in[j] = 1'b0;
               end
               OP_LINK: begin
                  s_wr_en = 1'b1;
                  s_wr_addr = j;
                  s_wr_data = cur_ff.succ[JobW-1:0];
                  hass_in[j] = 1'b1;
                  a_wr_en = 1'b1;
                  a_wr_addr = a_addr_ff;
                  if (cur_wait != WaitW'(MaxWait)) begin
                     a_wr_data = {aprio, cur_wait + WaitW'(1)};
                  end else begin
                     a_wr_data = {aprio, cur_wait};
                  end
                  aval_in[a_addr_ff] = 1'b1;
               end
               OP_SUBMIT: begin
                  if (cur_wait != '0) begin
                     status_in = ST_HELD;
                  end else begin
                     do_push = 1'b1;
                  end
               end
               OP_PICK: begin
                  if (!pick_any_ff) begin
                     status_in = ST_NONE;
                  end else begin
                     jout_in = 6'(q_rd_data);
                     head_in[pick_q_ff] = head_ff[pick_q_ff] + QPtrW'(1);
                     fill_in[pick_q_ff] = fill_ff[pick_q_ff] - QFillW'(1);
                     total_in = total_ff - TotalW'(1);
                  end
               end
               OP_COMPLETE: begin
                  if (hass_ff[j] && cur_wait != '0) begin
                     a_wr_en = 1'b1;
                     a_wr_addr = a_addr_ff;
                     a_wr_data = {aprio, cur_wait - WaitW'(1)};
                     if (cur_wait == WaitW'(1)) begin
                        jout_in = 6'(a_addr_ff);
                        pj = a_addr_ff;
                        do_push = 1'b1;
                        status_in = ST_RELEASED;
                     end
                  end
               end
               default: ;
            endcase
            if (do_push) begin
               if (fill_ff[pp] == QFillW'(QueueDepth)) begin
                  status_in = ST_FULL;
               end else begin
                  q_wr_en = 1'b1;
                  q_wr_addr = StoreAw'({pp, tail_ff[pp]});
                  q_wr_data = pj;
                  tail_in[pp] = tail_ff[pp] + QPtrW'(1);
                  fill_in[pp] = fill_ff[pp] + QFillW'(1);
                  total_in = total_ff + TotalW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         total_ff <= '0;
         hass_ff <= '0;
         aval_ff <= '0;
         for (int i = 0; i < NumPrio; i++) begin
            head_ff[i] <= '0; tail_ff[i] <= '0; fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         total_ff <= total_in;
         hass_ff <= hass_in;
         aval_ff <= aval_in;
         head_ff <= head_in; tail_ff <= tail_in; fill_ff <= fill_in;
      end
      status_ff <= status_in;
      jout_ff <= jout_in;
      a_addr_ff <= a_rd_addr;
      if (take) begin
         cur_ff <= cmd;
         pick_q_ff <= pick_q;
         pick_any_ff <= pick_any;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_job_out = jout_ff;
   assign rsp_ready_count = total_ff;
endmodule

>>> hw/rtl/priority_task_queue_with_dependencies.sv
`timescale 1ns / 1ps
// Strict-priority task scheduler with dependency counts. Commands (define,
// link, submit, pick, complete) are taken while busy is low and held in a
// two-entry queue. The execution unit keeps the job tables and the ready
// queues in memories with registered reads, so a command goes through a
// dispatch step (with the table and queue-store reads) and then an update
// step, and a complete has a successor read step between the two, since the
// successor must be read before its wait count can be. One result appears on
// the rsp_ ports, marked by rsp_valid for a single cycle, for every item; it
// is registered from the update step. The unit dispatches the next queued
// item once the update of the last one is done. The receiver cannot stall,
// so results must be captured in the cycle rsp_valid is high. Per-job flags
// stand in for the zeroed tables, so no clearing pass is needed after reset.
`include "assert_macros.svh"
module priority_task_queue_with_dependencies (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_operation,
   input  logic [5:0] req_job_id,
   input  logic [1:0] req_job_priority_in,
   input  logic [5:0] req_successor_id,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_job_out,
   output logic [8:0] rsp_ready_count
);
   import ptq_pkg::*;
   cmd_type cmd;
   logic    has_cmd, take;

   // The front part buffers accepted items.
   ptq_front u_front (
      .clock(clock), .reset(reset), .start(start),
      .req_operation(req_operation), .req_job_id(req_job_id),
      .req_job_priority_in(req_job_priority_in), .req_successor_id(req_successor_id),
      .take(take), .has_cmd(has_cmd), .cmd(cmd), .busy(busy)
   );

   // The back part executes one command at a time: dispatch, then update.
   ptq_back u_back (
      .clock(clock), .reset(reset), .has_cmd(has_cmd), .cmd(cmd), .take(take),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_job_out(rsp_job_out),
      .rsp_ready_count(rsp_ready_count)
   );

   // Dispatches and results are never back to back.
   `CHECK_NEXT(a_take_gap, clock, reset, take, !take)
   `CHECK_NEXT(a_no_double, clock, reset, rsp_valid, !rsp_valid)
   // Nothing is dispatched from an empty queue.
   `CHECK_IMPL(a_take_has, clock, reset, take, has_cmd)
   // The ready count never exceeds the total queue capacity.
   `CHECK_IMPL(a_count_range, clock, reset, 1'b1, rsp_ready_count <= 9'd256)
endmodule
